### sv/token_bucket_rate_limiter_core_assert.svh
// Assertion macros for the token bucket rate limiter core.
// Expects clk and rst_n in the scope of each use.
`ifndef TOKEN_BUCKET_RATE_LIMITER_CORE_ASSERT_SVH
`define TOKEN_BUCKET_RATE_LIMITER_CORE_ASSERT_SVH

// same-cycle implication
`define TBRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tbrl_pkg.sv
// Package for the token bucket rate limiter core: table geometry, codes,
// entry layout, sequencer states and the burst clamp function. No dependencies.
package tbrl_pkg;

  localparam int TB_DEPTH = 64;
  localparam int IDX_W    = $clog2(TB_DEPTH);
  localparam int CNT_W    = $clog2(TB_DEPTH + 1);
  localparam int CFG_AW   = 4;
  localparam int STEP_W   = 7;
  localparam int MUL_STEPS = 40;
  localparam int DIV_STEPS = 64;

  localparam logic [19:0] MICRO    = 20'd1000000;
  localparam logic [39:0] WAIT_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [63:0] TOK_MIN  = 64'hC000_0000_0000_0000;

  localparam logic [1:0] REQ_CHARGE = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] CLS_APP   = 2'd0;
  localparam logic [1:0] CLS_USER  = 2'd1;
  localparam logic [1:0] CLS_GROUP = 2'd2;

  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_MIN_BURST = 2'd1;
  localparam logic [1:0] REG_MAX_BURST = 2'd2;

  typedef struct packed {
    logic [1:0]  cls;
    logic        dir;
    logic [31:0] key;
    logic [39:0] rate;
    logic [63:0] tok;
    logic [47:0] last;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_COST, S_LOAD, S_FETCH, S_MUL, S_REFILL,
    S_CHARGE, S_DIVPREP, S_DIV, S_WB, S_SETNB, S_SETWR, S_OUT
  } state_t;

  function automatic logic [31:0] burst_q(logic [39:0] r, logic [31:0] mn,
                                          logic [31:0] mx);
    logic [37:0] q;
    q = r[39:2];
    if (q > {6'd0, mx}) q = {6'd0, mx};
    if (q < {6'd0, mn}) q = {6'd0, mn};
    return q[31:0];
  endfunction

endpackage

### sv/token_bucket_rate_limiter_core.sv
// Token bucket rate limiter core: bucket table, scan sequencer, shared
// shift-add multiplier and restoring divider. Depends on tbrl_pkg.
//
// One item is taken at a time; in_stall is high from the transfer until the
// result transfer. Every item first scans the bucket table, one entry a
// cycle. A charge request, when shaping is enabled, the byte count is
// nonzero and a bucket matched, then charges each matched bucket (up to 3):
// a 40-step multiply for the refill and, for a bucket left in debt, a
// 64-step divide for the wait. A set-rate item that updates a bucket also
// runs the refill multiply; an insert does not. Results wait in an output
// register held until out_stall is low.
module token_bucket_rate_limiter_core
  import tbrl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic              in_wr_dir,
  input  logic [1:0]        in_id_class,
  input  logic [31:0]       in_app_tag,
  input  logic [31:0]       in_user_id,
  input  logic [31:0]       in_group_id,
  input  logic [31:0]       in_entry_key,
  input  logic [31:0]       in_byte_count,
  input  logic [39:0]       in_rate,
  input  logic [47:0]       in_now_us,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [39:0]       out_wait_us,
  output logic              out_charged,
  output logic [1:0]        out_buckets_hit,
  output logic              out_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  state_t state_r, state_nxt;

  logic        enable_r;
  logic [31:0] min_burst_r, max_burst_r;
  logic [TB_DEPTH-1:0] valid_r, valid_nxt;

  entry_t tbl_mem_r [TB_DEPTH];
  entry_t rd_q;
  logic [IDX_W-1:0] raddr;
  logic             we;
  entry_t           wdata;

  logic [1:0]  rq_type_r, rq_cls_r;
  logic        rq_dir_r;
  logic [31:0] rq_app_r, rq_user_r, rq_group_r, rq_key_r, rq_bytes_r;
  logic [39:0] rq_rate_r;
  logic [47:0] rq_now_r;

  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       n_r, k_r;
  logic [IDX_W-1:0] hit_idx_r [3];
  logic             found_vld_r, free_vld_r, ins_r;
  logic [IDX_W-1:0] found_idx_r, free_idx_r, sel_idx_r;

  entry_t      w_ent_r;
  logic [63:0] burst_r, tok_r, dq_r, max_r;
  logic [51:0] cost_r;
  logic [87:0] prod_r;
  logic [47:0] mcand_r;
  logic [39:0] mplier_r, rem_r;
  logic [STEP_W-1:0] step_r;

  logic [39:0] out_wait_r;
  logic        out_charged_r, out_status_r;
  logic [1:0]  out_hit_r;

  logic              accept, cfg_wr;
  logic [IDX_W-1:0]  ci;
  logic              ci_valid, chg_match, set_match;
  logic [31:0]       key_sel;
  logic [31:0]       mul_a;
  logic [51:0]       mul_p;
  logic [47:0]       el;
  logic [63:0]       gap, t_ref, t_chg;
  logic [64:0]       t_chg65;
  logic [40:0]       trial;
  logic              div_ge;
  logic [63:0]       max_nxt;
  logic              shaping;

  assign accept = in_valid && !in_stall;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign shaping = enable_r && (rq_bytes_r != 32'd0) && (n_r != 2'd0);

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:    prdata = {31'd0, enable_r};
      REG_MIN_BURST: prdata = min_burst_r;
      REG_MAX_BURST: prdata = max_burst_r;
      default:       prdata = 32'd0;
    endcase
  end

  // scan compare on the entry read in the previous cycle
  assign ci       = IDX_W'(cnt_r - CNT_W'(1));
  assign ci_valid = valid_r[ci];

  always_comb begin
    case (rd_q.cls)
      CLS_APP:   key_sel = rq_app_r;
      CLS_USER:  key_sel = rq_user_r;
      CLS_GROUP: key_sel = rq_group_r;
      default:   key_sel = 32'd0;
    endcase
  end

  assign chg_match = ci_valid && (rd_q.dir == rq_dir_r) && (rd_q.cls != 2'd3) &&
                     (rd_q.key == key_sel);
  assign set_match = ci_valid && (rd_q.cls == rq_cls_r) && (rd_q.dir == rq_dir_r) &&
                     (rd_q.key == rq_key_r);

  // shared 32x20 multiplier for burst and cost
  always_comb begin
    case (state_r)
      S_COST:  mul_a = rq_bytes_r;
      S_FETCH: mul_a = burst_q(rd_q.rate, min_burst_r, max_burst_r);
      default: mul_a = burst_q(rq_rate_r, min_burst_r, max_burst_r);
    endcase
  end
  assign mul_p = mul_a * MICRO;

  assign el = (rq_now_r > rd_q.last) ? rq_now_r - rd_q.last : 48'd0;

  assign gap   = burst_r - w_ent_r.tok;
  assign t_ref = ($signed(w_ent_r.tok) >= $signed(burst_r)) ? burst_r :
                 (prod_r > {24'd0, gap}) ? burst_r : w_ent_r.tok + prod_r[63:0];

  assign t_chg65 = {tok_r[63], tok_r} - {13'd0, cost_r};
  assign t_chg   = ($signed(t_chg65) < $signed({1'b1, TOK_MIN})) ? TOK_MIN :
                   t_chg65[63:0];

  assign trial  = {rem_r, dq_r[63]};
  assign div_ge = trial >= {1'b0, w_ent_r.rate};

  assign max_nxt = (tok_r[63] && (dq_r > max_r)) ? dq_r : max_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (accept) state_nxt = S_SCAN;
      S_SCAN:    if (cnt_r == CNT_W'(TB_DEPTH)) state_nxt = S_DECIDE;
      S_DECIDE: begin
        state_nxt = S_OUT;
        if (rq_type_r == REQ_CHARGE) begin
          if (shaping) state_nxt = S_COST;
        end else if (rq_type_r == REQ_SET && rq_cls_r != 2'd3 &&
                     rq_rate_r != 40'd0) begin
          if (found_vld_r) state_nxt = S_LOAD;
          else if (free_vld_r) state_nxt = S_SETNB;
        end
      end
      S_COST:    state_nxt = S_LOAD;
      S_LOAD:    state_nxt = S_FETCH;
      S_FETCH:   state_nxt = S_MUL;
      S_MUL:     if (step_r == STEP_W'(MUL_STEPS - 1)) state_nxt = S_REFILL;
      S_REFILL:  state_nxt = (rq_type_r == REQ_CHARGE) ? S_CHARGE : S_SETNB;
      S_CHARGE:  state_nxt = S_DIVPREP;
      S_DIVPREP: state_nxt = tok_r[63] ? S_DIV : S_WB;
      S_DIV:     if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = S_WB;
      S_WB:      state_nxt = (k_r + 2'd1 == n_r) ? S_OUT : S_LOAD;
      S_SETNB:   state_nxt = S_SETWR;
      S_SETWR:   state_nxt = S_OUT;
      S_OUT:     if (!out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);
    raddr     = (state_r == S_SCAN) ? cnt_r[IDX_W-1:0] : sel_idx_r;
    we        = 1'b0;
    wdata     = w_ent_r;
    case (state_r)
      S_WB: begin
        we         = 1'b1;
        wdata.tok  = tok_r;
        wdata.last = rq_now_r;
      end
      S_SETWR: begin
        we         = 1'b1;
        wdata.cls  = rq_cls_r;
        wdata.dir  = rq_dir_r;
        wdata.key  = rq_key_r;
        wdata.rate = rq_rate_r;
        wdata.last = rq_now_r;
        if (ins_r || ($signed(tok_r) > $signed(burst_r))) wdata.tok = burst_r;
        else wdata.tok = tok_r;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (state_r == S_DECIDE) begin
      if (rq_type_r == REQ_CLEAR) valid_nxt = '0;
      else if (rq_type_r == REQ_SET && rq_cls_r != 2'd3 && rq_rate_r == 40'd0 &&
               found_vld_r) valid_nxt[found_idx_r] = 1'b0;
    end
    if (state_r == S_SETWR && ins_r) valid_nxt[sel_idx_r] = 1'b1;
    if (cfg_wr && paddr[3:2] == REG_ENABLE && !pwdata[0]) valid_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      enable_r    <= 1'b0;
      min_burst_r <= 32'd1048576;
      max_burst_r <= 32'd268435456;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ENABLE:    enable_r    <= pwdata[0];
          REG_MIN_BURST: min_burst_r <= pwdata;
          REG_MAX_BURST: max_burst_r <= pwdata;
          default:       enable_r    <= enable_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) tbl_mem_r[sel_idx_r] <= wdata;
    rd_q <= tbl_mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rq_type_r     <= in_req_type;
          rq_dir_r      <= in_wr_dir;
          rq_cls_r      <= in_id_class;
          rq_app_r      <= in_app_tag;
          rq_user_r     <= in_user_id;
          rq_group_r    <= in_group_id;
          rq_key_r      <= in_entry_key;
          rq_bytes_r    <= in_byte_count;
          rq_rate_r     <= in_rate;
          rq_now_r      <= in_now_us;
          cnt_r         <= '0;
          n_r           <= 2'd0;
          k_r           <= 2'd0;
          found_vld_r   <= 1'b0;
          free_vld_r    <= 1'b0;
          max_r         <= 64'd0;
          out_wait_r    <= 40'd0;
          out_charged_r <= 1'b0;
          out_hit_r     <= 2'd0;
          out_status_r  <= 1'b0;
        end
      end
      S_SCAN: begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r != '0) begin
          if (chg_match && n_r != 2'd3) begin
            hit_idx_r[n_r] <= ci;
            n_r            <= n_r + 2'd1;
          end
          if (set_match && !found_vld_r) begin
            found_vld_r <= 1'b1;
            found_idx_r <= ci;
          end
          if (!ci_valid && !free_vld_r) begin
            free_vld_r <= 1'b1;
            free_idx_r <= ci;
          end
        end
      end
      S_DECIDE: begin
        if (rq_type_r == REQ_CHARGE) out_hit_r <= n_r;
        ins_r     <= !found_vld_r;
        sel_idx_r <= found_vld_r ? found_idx_r : free_idx_r;
        if (rq_type_r == REQ_SET && rq_cls_r != 2'd3 && rq_rate_r != 40'd0 &&
            !found_vld_r && !free_vld_r) out_status_r <= 1'b1;
      end
      S_COST: begin
        cost_r    <= mul_p;
        sel_idx_r <= hit_idx_r[0];
      end
      S_FETCH: begin
        w_ent_r  <= rd_q;
        burst_r  <= {12'd0, mul_p};
        mcand_r  <= el;
        mplier_r <= rd_q.rate;
        prod_r   <= 88'd0;
        step_r   <= '0;
      end
      S_MUL: begin
        prod_r   <= {prod_r[86:0], 1'b0} + (mplier_r[39] ? {40'd0, mcand_r} : 88'd0);
        mplier_r <= {mplier_r[38:0], 1'b0};
        step_r   <= step_r + STEP_W'(1);
      end
      S_REFILL: tok_r <= t_ref;
      S_CHARGE: tok_r <= t_chg;
      S_DIVPREP: begin
        dq_r   <= ~tok_r + {24'd0, w_ent_r.rate};
        rem_r  <= 40'd0;
        step_r <= '0;
      end
      S_DIV: begin
        rem_r  <= div_ge ? 40'(trial - {1'b0, w_ent_r.rate}) : trial[39:0];
        dq_r   <= {dq_r[62:0], div_ge};
        step_r <= step_r + STEP_W'(1);
      end
      S_WB: begin
        max_r         <= max_nxt;
        k_r           <= k_r + 2'd1;
        sel_idx_r     <= hit_idx_r[k_r + 2'd1];
        out_charged_r <= 1'b1;
        out_wait_r    <= (max_nxt[63:40] != 24'd0) ? WAIT_MAX : max_nxt[39:0];
      end
      S_SETNB: burst_r <= {12'd0, mul_p};
      default: cnt_r <= cnt_r;
    endcase
  end

  assign out_wait_us     = out_wait_r;
  assign out_charged     = out_charged_r;
  assign out_buckets_hit = out_hit_r;
  assign out_status      = out_status_r;

`include "token_bucket_rate_limiter_core_assert.svh"

  `TBRL_ASSERT_IMP(a_busy_while_out, out_valid, in_stall, "input taken with result pending")
  `TBRL_ASSERT_IMP(a_charge_has_hit, out_valid && out_charged, out_buckets_hit != 2'd0, "charge without hit")
  `TBRL_ASSERT_IMP(a_full_no_charge, out_valid && out_status, !out_charged && out_buckets_hit == 2'd0, "table full on charge")
  `TBRL_ASSERT_NXT(a_accept_scan, in_valid && !in_stall, state_r == S_SCAN && cnt_r == '0, "scan not started")

endmodule

### test/testbench.sv
// Self-checking testbench for token_bucket_rate_limiter_core: directed table plus random
// traffic, scored against an in-bench bucket table predictor. Depends on tbrl_pkg.
`timescale 1ns / 100ps

module testbench;
  import tbrl_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [1:0] CLS_NONE = 2'd3;
  localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;
  localparam logic [39:0] RATE_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] NOW_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        wr_dir;
    logic [1:0]  id_class;
    logic [31:0] app_tag;
    logic [31:0] user_id;
    logic [31:0] group_id;
    logic [31:0] entry_key;
    logic [31:0] byte_count;
    logic [39:0] rate;
    logic [47:0] now_us;
  } req_t;

  typedef struct packed {
    logic [39:0] wait_us;
    logic        charged;
    logic [1:0]  buckets_hit;
    logic        status;
  } res_t;

  typedef struct {
    req_t it;
    bit   fixed;
    res_t res;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic in_wr_dir = 0;
  logic [1:0] in_id_class = '0;
  logic [31:0] in_app_tag = '0, in_user_id = '0, in_group_id = '0;
  logic [31:0] in_entry_key = '0, in_byte_count = '0;
  logic [39:0] in_rate = '0;
  logic [47:0] in_now_us = '0;
  logic out_valid;
  logic out_stall = 1;
  logic [39:0] out_wait_us;
  logic out_charged;
  logic [1:0] out_buckets_hit;
  logic out_status;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  token_bucket_rate_limiter_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_wr_dir(in_wr_dir), .in_id_class(in_id_class),
    .in_app_tag(in_app_tag), .in_user_id(in_user_id), .in_group_id(in_group_id),
    .in_entry_key(in_entry_key), .in_byte_count(in_byte_count), .in_rate(in_rate),
    .in_now_us(in_now_us),
    .out_valid(out_valid), .out_stall(out_stall), .out_wait_us(out_wait_us),
    .out_charged(out_charged), .out_buckets_hit(out_buckets_hit), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // bucket table shadow
  bit                  shaping_on;
  longint unsigned     burst_lo, burst_hi;
  bit                  bk_valid [TB_DEPTH];
  logic [1:0]          bk_cls   [TB_DEPTH];
  logic                bk_dir   [TB_DEPTH];
  logic [31:0]         bk_key   [TB_DEPTH];
  longint unsigned     bk_rate  [TB_DEPTH];
  longint              bk_tok   [TB_DEPTH];
  longint unsigned     bk_last  [TB_DEPTH];

  res_t pending_results[$];
  row_t stim_table[$];
  int   n_mismatch = 0;
  bit   quiet = 0;
  int   hold_req = 0;
  logic [47:0] clock_us = '0;

  function automatic longint burst_micro(longint unsigned r);
    longint unsigned q;
    q = r >> 2;
    if (q > burst_hi) q = burst_hi;
    if (q < burst_lo) q = burst_lo;
    return longint'(q * 64'd1000000);
  endfunction

  function automatic void refill_bucket(int i, longint unsigned now);
    longint burst, t;
    longint unsigned el, gap, rt;
    burst = burst_micro(bk_rate[i]);
    t = bk_tok[i];
    el = (now > bk_last[i]) ? now - bk_last[i] : 64'd0;
    if (t >= burst) begin
      t = burst;
    end else begin
      gap = $unsigned(burst) - $unsigned(t);
      rt = bk_rate[i];
      if (el != 0 && rt > gap / el) t = burst;
      else t = longint'($unsigned(t) + el * rt);
    end
    bk_tok[i] = t;
    bk_last[i] = now;
  endfunction

  function automatic res_t predict_step(req_t it);
    res_t r;
    int idx[3];
    int n, found, freei, j;
    logic [31:0] ids[3];
    longint cost, t, nb;
    longint unsigned debt, w, longest, rt, now;
    r = '0;
    n = 0;
    longest = 0;
    now = it.now_us;
    ids[0] = it.app_tag;
    ids[1] = it.user_id;
    ids[2] = it.group_id;
    case (it.req_type)
      REQ_CHARGE: begin
        for (int i = 0; i < TB_DEPTH && n < 3; i++) begin
          if (bk_valid[i] && bk_dir[i] == it.wr_dir && bk_cls[i] != CLS_NONE &&
              bk_key[i] == ids[bk_cls[i]]) begin
            idx[n] = i;
            n++;
          end
        end
        r.buckets_hit = n[1:0];
        if (shaping_on && it.byte_count != 0 && n > 0) begin
          cost = longint'(64'(it.byte_count) * 64'd1000000);
          for (int k = 0; k < n; k++) begin
            j = idx[k];
            refill_bucket(j, now);
            t = bk_tok[j] - cost;
            if (t < $signed(TOK_MIN)) t = $signed(TOK_MIN);
            bk_tok[j] = t;
            if (t < 0) begin
              debt = 64'd0 - $unsigned(t);
              rt = bk_rate[j];
              w = (debt + rt - 1) / rt;
              if (w > longest) longest = w;
            end
          end
          if (longest > WAIT_MAX) longest = WAIT_MAX;
          r.wait_us = longest[39:0];
          r.charged = 1;
        end
      end
      REQ_SET: begin
        if (it.id_class != CLS_NONE) begin
          found = -1;
          freei = -1;
          for (int i = 0; i < TB_DEPTH; i++) begin
            if (bk_valid[i]) begin
              if (found < 0 && bk_cls[i] == it.id_class && bk_dir[i] == it.wr_dir &&
                  bk_key[i] == it.entry_key) found = i;
            end else if (freei < 0) begin
              freei = i;
            end
          end
          if (it.rate == 0) begin
            if (found >= 0) bk_valid[found] = 0;
          end else if (found >= 0) begin
            nb = burst_micro(it.rate);
            refill_bucket(found, now);
            if (bk_tok[found] > nb) bk_tok[found] = nb;
            bk_rate[found] = it.rate;
          end else if (freei >= 0) begin
            bk_valid[freei] = 1;
            bk_cls[freei] = it.id_class;
            bk_dir[freei] = it.wr_dir;
            bk_key[freei] = it.entry_key;
            bk_rate[freei] = it.rate;
            bk_tok[freei] = burst_micro(it.rate);
            bk_last[freei] = now;
          end else begin
            r.status = 1;
          end
        end
      end
      REQ_CLEAR: begin
        foreach (bk_valid[i]) bk_valid[i] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // values seen just before each rising edge
  logic in_stall_s = 1, out_valid_s = 0, out_stall_s = 1;
  res_t got_s;
  always @(negedge clk) begin
    in_stall_s <= in_stall;
    out_valid_s <= out_valid;
    out_stall_s <= out_stall;
    got_s <= '{out_wait_us, out_charged, out_buckets_hit, out_status};
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid_s && !out_stall_s) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        $display("%0t unexpected result transfer wait_us %0d", $time, got_s.wait_us);
      end else begin
        e = pending_results.pop_front();
        if (e.wait_us != got_s.wait_us) begin
          n_mismatch++;
          $display("%0t wait_us exp %0d act %0d", $time, e.wait_us, got_s.wait_us);
        end
        if (e.charged != got_s.charged) begin
          n_mismatch++;
          $display("%0t charged exp %0d act %0d", $time, e.charged, got_s.charged);
        end
        if (e.buckets_hit != got_s.buckets_hit) begin
          n_mismatch++;
          $display("%0t buckets_hit exp %0d act %0d", $time, e.buckets_hit,
                   got_s.buckets_hit);
        end
        if (e.status != got_s.status) begin
          n_mismatch++;
          $display("%0t status exp %0d act %0d", $time, e.status, got_s.status);
        end
      end
    end
  end

  // receiver back-pressure
  int hold_seen = 0, hold_left = 0, run_left = 0;
  always @(posedge clk) begin
    int s;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      out_stall <= 1;
      hold_left--;
    end else if (quiet) begin
      out_stall <= 0;
    end else if (run_left > 0) begin
      run_left--;
    end else begin
      s = $urandom_range(0, 99);
      if (s < 30) begin
        out_stall <= 1;
        run_left = $urandom_range(0, 3);
      end else if (s < 38) begin
        out_stall <= 1;
        run_left = $urandom_range(20, 80);
      end else begin
        out_stall <= 0;
        run_left = $urandom_range(0, 15);
      end
    end
  end

  function automatic int pick_gap();
    int s;
    if (quiet) return 0;
    s = $urandom_range(0, 99);
    if (s < 55) return 0;
    if (s < 88) return $urandom_range(1, 4);
    return $urandom_range(15, 70);
  endfunction

  task automatic push_item(req_t it, bit fixed, res_t fixed_res);
    res_t e;
    int g;
    in_valid <= 1;
    in_req_type <= it.req_type;
    in_wr_dir <= it.wr_dir;
    in_id_class <= it.id_class;
    in_app_tag <= it.app_tag;
    in_user_id <= it.user_id;
    in_group_id <= it.group_id;
    in_entry_key <= it.entry_key;
    in_byte_count <= it.byte_count;
    in_rate <= it.rate;
    in_now_us <= it.now_us;
    do @(posedge clk); while (in_stall_s);
    e = predict_step(it);
    pending_results.insert(pending_results.size(), fixed ? fixed_res : e);
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] reg_idx, logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    case (reg_idx)
      REG_ENABLE: begin
        shaping_on = value[0];
        if (!value[0]) foreach (bk_valid[i]) bk_valid[i] = 0;
      end
      REG_MIN_BURST: burst_lo = value;
      REG_MAX_BURST: burst_hi = value;
      default: ;
    endcase
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(bit en, logic [31:0] mn, logic [31:0] mx);
    write_reg(REG_MIN_BURST, mn);
    write_reg(REG_MAX_BURST, mx);
    write_reg(REG_ENABLE, {31'd0, en});
  endtask

  function automatic req_t mk_req(logic [1:0] typ, logic wr, logic [1:0] cls,
                                  logic [31:0] app, logic [31:0] usr, logic [31:0] grp,
                                  logic [31:0] key, logic [31:0] bytes, logic [39:0] rate,
                                  logic [47:0] now);
    req_t it;
    it = '{typ, wr, cls, app, usr, grp, key, bytes, rate, now};
    return it;
  endfunction

  function automatic void add_row(req_t it, bit fixed, res_t res);
    row_t row;
    row.it = it;
    row.fixed = fixed;
    row.res = res;
    stim_table.insert(stim_table.size(), row);
  endfunction

  function automatic logic [31:0] pick_id();
    logic [31:0] pool[6] = '{32'd0, 32'd1, ALL1, 32'h5A5A_A5A5, 32'd7, 32'h8000_0000};
    if ($urandom_range(0, 9) == 0) return $urandom;
    return pool[$urandom_range(0, 5)];
  endfunction

  function automatic req_t rand_item();
    req_t it;
    int s;
    s = $urandom_range(0, 99);
    it.req_type = s < 62 ? REQ_CHARGE : s < 93 ? REQ_SET : s < 96 ? REQ_CLEAR : REQ_NONE;
    it.wr_dir = 1'($urandom_range(0, 1));
    it.id_class = ($urandom_range(0, 9) == 0) ? CLS_NONE : 2'($urandom_range(0, 2));
    it.app_tag = pick_id();
    it.user_id = pick_id();
    it.group_id = pick_id();
    it.entry_key = pick_id();
    s = $urandom_range(0, 99);
    it.byte_count = s < 10 ? 32'd0 : s < 20 ? 32'($urandom) : s < 28 ? ALL1 :
                    32'($urandom_range(1, 2_000_000));
    s = $urandom_range(0, 99);
    it.rate = s < 8 ? 40'd0 : s < 18 ? 40'({$urandom, $urandom}) : s < 23 ? RATE_MAX :
              40'($urandom_range(1, 50_000_000));
    s = $urandom_range(0, 99);
    if (s < 5) clock_us = clock_us - 48'($urandom_range(0, 5000));
    else if (s < 8) clock_us = 48'({$urandom, $urandom});
    else clock_us = clock_us + 48'($urandom_range(0, 2000));
    it.now_us = clock_us;
    return it;
  endfunction

  localparam int SPLIT = 6;

  initial begin
    res_t z;
    z = '0;
    shaping_on = 0;
    burst_lo = 1048576;
    burst_hi = 268435456;
    foreach (bk_valid[i]) bk_valid[i] = 0;

    // shaping off
    add_row(mk_req(REQ_CHARGE, 0, CLS_APP, 0, 0, 0, 0, 0, 0, 0), 1, z);
    add_row(mk_req(REQ_NONE, 1, CLS_NONE, ALL1, ALL1, ALL1, ALL1, ALL1, RATE_MAX, NOW_MAX),
            1, z);
    add_row(mk_req(REQ_SET, 0, CLS_NONE, 0, 0, 0, 9, 0, 1000, 0), 1, z);
    add_row(mk_req(REQ_SET, 0, CLS_APP, 0, 0, 0, 9, 0, 0, 0), 1, z);
    add_row(mk_req(REQ_SET, 0, CLS_APP, 0, 0, 0, 1, 0, 4_000_000, 0), 1, z);
    add_row(mk_req(REQ_CHARGE, 0, CLS_APP, 1, 0, 0, 0, 100, 0, 5), 1, '{0, 0, 2'd1, 0});
    // shaping on
    add_row(mk_req(REQ_CHARGE, 0, CLS_APP, 1, 0, 0, 0, 100, 0, 10), 0, z);
    add_row(mk_req(REQ_CHARGE, 0, CLS_APP, 1, 0, 0, 0, 0, 0, 10), 1, '{0, 0, 2'd1, 0});
    add_row(mk_req(REQ_SET, 1, CLS_USER, 0, 0, 0, 2, 0, RATE_MAX, 20), 0, z);
    add_row(mk_req(REQ_SET, 1, CLS_GROUP, 0, 0, 0, 3, 0, 1, 20), 0, z);
    add_row(mk_req(REQ_CHARGE, 1, CLS_APP, 0, 2, 3, 0, ALL1, 0, 30), 0, z);
    add_row(mk_req(REQ_SET, 1, CLS_APP, 0, 0, 0, 5, 0, 1, 30), 0, z);
    add_row(mk_req(REQ_CHARGE, 1, CLS_APP, 5, 2, 3, 0, ALL1, 0, 30), 0, z);
    add_row(mk_req(REQ_CHARGE, 1, CLS_APP, 5, 2, 3, 0, ALL1, 0, 5), 0, z);
    add_row(mk_req(REQ_SET, 1, CLS_USER, 0, 0, 0, 2, 0, 8, 40), 0, z);
    add_row(mk_req(REQ_SET, 1, CLS_GROUP, 0, 0, 0, 3, 0, 0, 40), 0, z);
    add_row(mk_req(REQ_CHARGE, 1, CLS_APP, ALL1, ALL1, ALL1, ALL1, 1, 0, NOW_MAX), 0, z);
    add_row(mk_req(REQ_CHARGE, 1, CLS_APP, 5, 2, 3, 0, 1, 0, NOW_MAX), 0, z);
    add_row(mk_req(REQ_CLEAR, 0, CLS_APP, 0, 0, 0, 0, 0, 0, 50), 1, z);
    add_row(mk_req(REQ_CHARGE, 0, CLS_APP, 1, 0, 0, 0, 100, 0, 60), 1, z);
    add_row(mk_req(REQ_SET, 0, CLS_APP, 0, 0, 0, ALL1, 0, RATE_MAX, NOW_MAX), 0, z);
    add_row(mk_req(REQ_CHARGE, 0, CLS_APP, ALL1, 0, 0, 0, ALL1, 0, NOW_MAX), 0, z);

    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (i == SPLIT) begin
        wait_idle();
        write_reg(REG_ENABLE, 32'd1);
      end
      push_item(stim_table[i].it, stim_table[i].fixed, stim_table[i].res);
    end
    wait_idle();

    // crossed clamps, then fill the table past its depth
    apply_cfg(1, ALL1, 32'd0);
    push_item(mk_req(REQ_CLEAR, 0, CLS_APP, 0, 0, 0, 0, 0, 0, 0), 0, z);
    for (int k = 0; k <= TB_DEPTH; k++)
      push_item(mk_req(REQ_SET, 0, CLS_USER, 0, 0, 0, 1000 + k, 0, 1000, 100), 0, z);
    push_item(mk_req(REQ_SET, 0, CLS_USER, 0, 0, 0, 1000, 0, 0, 100), 0, z);
    push_item(mk_req(REQ_SET, 0, CLS_USER, 0, 0, 0, 2000, 0, 1000, 100), 0, z);
    push_item(mk_req(REQ_CHARGE, 0, CLS_APP, 0, 1001, 0, 0, ALL1, 0, 200), 0, z);
    wait_idle();

    // drive one bucket into deep debt
    apply_cfg(1, 32'd1048576, 32'd268435456);
    quiet = 1;
    push_item(mk_req(REQ_CLEAR, 0, CLS_APP, 0, 0, 0, 0, 0, 0, 0), 0, z);
    push_item(mk_req(REQ_SET, 0, CLS_APP, 0, 0, 0, 77, 0, 1, 100), 0, z);
    repeat (40) push_item(mk_req(REQ_CHARGE, 0, CLS_APP, 77, 0, 0, 0, ALL1, 0, 100), 0, z);
    wait_idle();
    quiet = 0;

    // random phases over several clamp settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_cfg(1, 32'd1048576, 32'd268435456);
        1: apply_cfg(1, 32'd0, ALL1);
        2: apply_cfg(1, ALL1, 32'd0);
        3: apply_cfg(1, 32'd100, 32'd5000);
        4: apply_cfg(0, 32'd1000, 32'd1000000);
        default: apply_cfg(1, 32'd0, 32'd0);
      endcase
      quiet = (p == 1);
      if (p == 0) hold_req++;
      repeat (120) push_item(rand_item(), 0, z);
      wait_idle();
    end
    quiet = 0;

    repeat (300) @(posedge clk);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0t results still outstanding: %0d", $time, pending_results.size());
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/tbrl_pkg.sv
sv/token_bucket_rate_limiter_core.sv
test/testbench.sv
